// ===== rtl/core/wbbs_pkg.sv =====
`default_nettype none
package wbbs_pkg;

  // defaults for the top-level parameters
  localparam int WAYPOINT_DEPTH_DEF = 64;
  localparam int CORDIC_STEPS_DEF   = 16;

  // CORDIC datapath
  localparam int CORDIC_FRAC = 8;        // dx, dy scaled by 2^8
  localparam int CORDIC_XW   = 28;       // signed x/y register width
  localparam int STEP_W      = 5;        // step counter, up to 24 steps
  localparam int PROD_W      = 43;       // 27-bit magnitude x 16-bit gain
  localparam int DIST_W      = 17;
  localparam logic [15:0] CORDIC_GAIN_INV = 16'd39797;
  localparam logic [DIST_W-1:0] DIST_SAT  = 17'd131071;

  // configuration register indexes
  localparam logic [2:0] REG_ARRIVAL_RADIUS   = 3'd0;
  localparam logic [2:0] REG_FENCE_X_MIN      = 3'd1;
  localparam logic [2:0] REG_FENCE_X_MAX      = 3'd2;
  localparam logic [2:0] REG_FENCE_Y_MIN      = 3'd3;
  localparam logic [2:0] REG_FENCE_Y_MAX      = 3'd4;
  localparam logic [2:0] REG_TURN_RATE_MAX    = 3'd5;
  localparam logic [2:0] REG_SPEED_MAX        = 3'd6;
  localparam logic [2:0] REG_HEADING_DEADBAND = 3'd7;

  // configuration reset values
  localparam logic [14:0] RST_ARRIVAL_RADIUS   = 15'd307;
  localparam logic [15:0] RST_FENCE_X_MIN      = 16'hFA8F;  // -1393
  localparam logic [15:0] RST_FENCE_X_MAX      = 16'd2048;
  localparam logic [15:0] RST_FENCE_Y_MIN      = 16'hF8CD;  // -1843
  localparam logic [15:0] RST_FENCE_Y_MAX      = 16'd2048;
  localparam logic [14:0] RST_TURN_RATE_MAX    = 15'd614;
  localparam logic [14:0] RST_SPEED_MAX        = 15'd307;
  localparam logic [14:0] RST_HEADING_DEADBAND = 15'd3277;

  // input opcodes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_POSE = 1'b1;

  // result event codes
  localparam logic [1:0] EV_STEER   = 2'd0;
  localparam logic [1:0] EV_REACHED = 2'd1;
  localparam logic [1:0] EV_FENCE   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_CORDIC,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_ROT,
    C_MUL,
    C_RND
  } cordic_state_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] len;
    logic [15:0]       bear;
  } cres_t;

  // atan(2^-i) in 32-bit binary angle
  function automatic logic [31:0] atan_at(input logic [STEP_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/wbbs_ram.sv =====
`default_nettype none
module wbbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/wbbs_cordic.sv =====
`default_nettype none
module wbbs_cordic #(
  parameter int CORDIC_STEPS = wbbs_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [16:0]   dx,
  input  wire logic signed [16:0]   dy,
  output wbbs_pkg::cres_t           res
);
  import wbbs_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  cordic_state_t state, state_next;

  logic signed [CORDIC_XW-1:0] x, y;
  logic [31:0]                 z;
  logic [STEP_W-1:0]           step;
  logic                        zero_vec;
  logic [PROD_W-1:0]           prod;
  logic [DIST_W-1:0]           len;
  logic [15:0]                 bear;
  logic                        done;

  logic signed [CORDIC_XW-1:0] x0, y0, xs, ys;
  logic [CORDIC_XW-2:0]        xmag;
  logic [PROD_W-1:0]           rnd;
  logic [PROD_W-25:0]          dq;
  logic [31:0]                 zr;

  // scale by 2^8
  assign x0   = {{(CORDIC_XW-17-CORDIC_FRAC){dx[16]}}, dx, {CORDIC_FRAC{1'b0}}};
  assign y0   = {{(CORDIC_XW-17-CORDIC_FRAC){dy[16]}}, dy, {CORDIC_FRAC{1'b0}}};
  // shared shifter: floor shift of both coordinates
  assign xs   = x >>> step;
  assign ys   = y >>> step;
  assign xmag = x[CORDIC_XW-1] ? '0 : x[CORDIC_XW-2:0];
  assign rnd  = prod + PROD_W'(32'h0080_0000);
  assign dq   = rnd[PROD_W-1:24];
  assign zr   = z + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == C_RND);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:  if (start) state_next = C_ROT;
      C_ROT:   if (step == LAST_STEP) state_next = C_MUL;
      C_MUL:   state_next = C_RND;
      C_RND:   state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          zero_vec <= (dx == '0) && (dy == '0);
          step     <= '0;
          // pre-rotate into the right half plane
          if (dx[16]) begin
            x <= -x0;
            y <= -y0;
            z <= 32'h8000_0000;
          end else begin
            x <= x0;
            y <= y0;
            z <= 32'h0;
          end
        end
      end
      C_ROT: begin
        if (!y[CORDIC_XW-1]) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_at(step);
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_at(step);
        end
        step <= step + STEP_W'(1);
      end
      C_MUL: begin
        prod <= PROD_W'(xmag) * PROD_W'(CORDIC_GAIN_INV);
      end
      C_RND: begin
        if (zero_vec) begin
          len  <= '0;
          bear <= '0;
        end else begin
          len  <= (dq > PROD_W'(DIST_SAT)) ? DIST_SAT : dq[DIST_W-1:0];
          bear <= zr[31:16];
        end
      end
      default: ;
    endcase
  end

  assign res.done = done;
  assign res.len  = len;
  assign res.bear = bear;

endmodule
`default_nettype wire

// ===== rtl/core/waypoint_bang_bang_steering.sv =====
// Waypoint follower with bang-bang steering.
// Add word: no result; the next word may follow at once.
// Pose word: a fence hit skips the CORDIC and goes from accept to S_DONE; a pose that
// reaches the CORDIC waits on the rotator, which does one step a cycle.
// in_ready is low from the accept of a pose that gives a result until that result is in the output register.
// Reset (rst, sync): store empty, index zero, block asleep, config at its reset values.
`default_nettype none
module waypoint_bang_bang_steering #(
  parameter int WAYPOINT_DEPTH = wbbs_pkg::WAYPOINT_DEPTH_DEF,
  parameter int CORDIC_STEPS   = wbbs_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  // input words
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] heading,
  // result words
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              event_res,
  output logic signed [15:0]      turn_cmd,
  output logic [14:0]             speed_cmd,
  output logic [16:0]             distance,
  output logic signed [15:0]      bearing,
  output logic signed [15:0]      heading_echo,
  output logic                    all_done
);
  import wbbs_pkg::*;

  localparam int AW = $clog2(WAYPOINT_DEPTH);
  localparam int CW = $clog2(WAYPOINT_DEPTH + 1);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [14:0]        arrival_radius;
  logic signed [15:0] fence_x_min, fence_x_max, fence_y_min, fence_y_max;
  logic [14:0]        turn_rate_max, speed_max, heading_deadband;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrival_radius   <= RST_ARRIVAL_RADIUS;
      fence_x_min      <= RST_FENCE_X_MIN;
      fence_x_max      <= RST_FENCE_X_MAX;
      fence_y_min      <= RST_FENCE_Y_MIN;
      fence_y_max      <= RST_FENCE_Y_MAX;
      turn_rate_max    <= RST_TURN_RATE_MAX;
      speed_max        <= RST_SPEED_MAX;
      heading_deadband <= RST_HEADING_DEADBAND;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_ARRIVAL_RADIUS:   arrival_radius   <= cfg_data[14:0];
        REG_FENCE_X_MIN:      fence_x_min      <= cfg_data;
        REG_FENCE_X_MAX:      fence_x_max      <= cfg_data;
        REG_FENCE_Y_MIN:      fence_y_min      <= cfg_data;
        REG_FENCE_Y_MAX:      fence_y_max      <= cfg_data;
        REG_TURN_RATE_MAX:    turn_rate_max    <= cfg_data[14:0];
        REG_SPEED_MAX:        speed_max        <= cfg_data[14:0];
        REG_HEADING_DEADBAND: heading_deadband <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Sequencer state and waypoint bookkeeping
  // ---------------------------------------------------------------
  seq_state_t state, state_next;

  logic [CW-1:0] wp_count;   // waypoints stored
  logic [CW-1:0] cur_index;  // waypoint being chased
  logic          active;

  // latched pose
  logic signed [15:0] px, py, hd;
  logic               fence_hit;

  logic accept, is_add, is_pose, have_wp, outside, slot_free, load_out;
  logic [CW-1:0] idx_inc;
  logic          last_passed;

  assign accept    = in_valid && in_ready;
  assign is_add    = accept && (op == OP_ADD);
  assign is_pose   = accept && (op == OP_POSE) && active;
  assign have_wp   = (cur_index < wp_count);
  // bounds are inclusive; a crossed fence rejects every pose
  assign outside   = (pos_x < fence_x_min) || (pos_x > fence_x_max) ||
                     (pos_y < fence_y_min) || (pos_y > fence_y_max);
  assign slot_free = !out_valid || out_ready;
  assign load_out  = (state == S_DONE) && slot_free;
  assign idx_inc   = cur_index + CW'(1);
  assign last_passed = (idx_inc >= wp_count);

  assign in_ready = (state == S_IDLE);

  // ---------------------------------------------------------------
  // Waypoint store: x in the low half, y in the high half
  // ---------------------------------------------------------------
  logic          ram_we;
  logic [31:0]   ram_rdata;

  assign ram_we = is_add && (wp_count < CW'(WAYPOINT_DEPTH));

  wbbs_ram #(
    .WIDTH (32),
    .DEPTH (WAYPOINT_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_count[AW-1:0]),
    .wdata ({pos_y, pos_x}),
    .raddr (cur_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------
  // CORDIC: vectoring on (waypoint - pose). The read port addresses
  // cur_index all the time, so the entry is in ram_rdata in S_LOAD.
  // ---------------------------------------------------------------
  logic signed [16:0] dx, dy;
  cres_t              cres;

  assign dx = {ram_rdata[15], ram_rdata[15:0]}  - {px[15], px};
  assign dy = {ram_rdata[31], ram_rdata[31:16]} - {py[15], py};

  wbbs_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_LOAD),
    .dx    (dx),
    .dy    (dy),
    .res   (cres)
  );

  // ---------------------------------------------------------------
  // Result decision
  // ---------------------------------------------------------------
  logic               reached;
  logic [15:0]        err;
  logic signed [16:0] err_ext;
  logic [16:0]        err_mag;
  logic signed [15:0] turn_val;
  logic [15:0]        rate_ext;

  assign reached  = (cres.len < {2'b00, arrival_radius});
  // heading error with natural binary-angle wrap
  assign err      = cres.bear + hd;
  assign err_ext  = {err[15], err};
  assign err_mag  = err[15] ? 17'(-err_ext) : 17'(err_ext);
  assign rate_ext = {1'b0, turn_rate_max};

  always_comb begin
    if (err_mag < {2'b00, heading_deadband}) begin
      turn_val = '0;
    end else if (!err[15] && (err != '0)) begin
      turn_val = rate_ext;
    end else begin
      turn_val = -rate_ext;
    end
  end

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (is_pose && have_wp) begin
          state_next = outside ? S_DONE : S_LOAD;
        end
      end
      S_LOAD:   state_next = S_CORDIC;
      S_CORDIC: if (cres.done) state_next = S_DONE;
      S_DONE:   if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp_count  <= '0;
      cur_index <= '0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ram_we) begin
        wp_count <= wp_count + CW'(1);
      end
      if (is_add) begin
        active <= 1'b1;
      end else if (is_pose && !have_wp) begin
        active <= 1'b0;  // nothing left to chase
      end
      if (load_out && (fence_hit || reached)) begin
        cur_index <= idx_inc;
        if (last_passed) begin
          active <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pose latch
  always_ff @(posedge clk) begin
    if (is_pose && have_wp) begin
      px        <= pos_x;
      py        <= pos_y;
      hd        <= heading;
      fence_hit <= outside;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (fence_hit) begin
        event_res    <= EV_FENCE;
        turn_cmd     <= '0;
        speed_cmd    <= '0;
        distance     <= '0;
        bearing      <= '0;
        heading_echo <= '0;
        all_done     <= last_passed;
      end else if (reached) begin
        event_res    <= EV_REACHED;
        turn_cmd     <= '0;
        speed_cmd    <= '0;
        distance     <= cres.len;
        bearing      <= cres.bear;
        heading_echo <= hd;
        all_done     <= last_passed;
      end else begin
        event_res    <= EV_STEER;
        turn_cmd     <= turn_val;
        speed_cmd    <= speed_max;
        distance     <= cres.len;
        bearing      <= cres.bear;
        heading_echo <= hd;
        all_done     <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    cur_index <= wp_count)
    else $error("waypoint index ran past the stored count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wp_count <= CW'(WAYPOINT_DEPTH))
    else $error("waypoint count exceeds store depth");

  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cres.done |-> (state == S_CORDIC))
    else $error("CORDIC finished outside its wait state");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result word appeared without a finished pose");

endmodule
`default_nettype wire

// ===== dv/tb_waypoint_bang_bang_steering.sv =====
module tb_waypoint_bang_bang_steering;
  timeunit 1ns;
  timeprecision 1ps;

  import wbbs_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int WP_DEPTH      = WAYPOINT_DEPTH_DEF;
  localparam int ROT_STEPS     = CORDIC_STEPS_DEF;
  // covers the longest pose through the CORDIC, with margin on top
  localparam int SETTLE_CYCLES = ROT_STEPS + 15;
  localparam int PHASE_WORDS   = 117;
  localparam int NUM_PHASES    = 6;
  localparam int MAX_SHOWN     = 10;
  localparam int GAIN_INV      = 39797;   // round(2^16 / 1.6467602)
  localparam int DIST_MAX      = 131071;

  // atan(2^-i), 2^32 per full turn
  localparam logic [31:0] ATAN_LUT [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct {
    logic [1:0]         ev;
    logic signed [15:0] turn;
    logic [14:0]        speed;
    logic [16:0]        len;
    logic signed [15:0] bear;
    logic signed [15:0] hdg;
    logic               done;
  } steer_result_t;

  // Tracks the follower state and config, predicts one result per pose word
  // that has a waypoint to chase, and compares results in order.
  class steer_scoreboard;
    logic signed [15:0] wp_x [WP_DEPTH];
    logic signed [15:0] wp_y [WP_DEPTH];
    int                 wp_count;
    int                 wp_index;
    bit                 active;
    logic [14:0]        arrival_radius;
    logic signed [15:0] fence_x_min;
    logic signed [15:0] fence_x_max;
    logic signed [15:0] fence_y_min;
    logic signed [15:0] fence_y_max;
    logic [14:0]        turn_rate_max;
    logic [14:0]        speed_max;
    logic [14:0]        heading_deadband;
    steer_result_t      expected_q[$];
    int                 live_words;   // words the block did not just ignore
    int                 errors;
    int                 shown;

    function new();
      wp_count         = 0;
      wp_index         = 0;
      active           = 1'b0;
      arrival_radius   = 15'd307;
      fence_x_min      = -16'sd1393;
      fence_x_max      = 16'sd2048;
      fence_y_min      = -16'sd1843;
      fence_y_max      = 16'sd2048;
      turn_rate_max    = 15'd614;
      speed_max        = 15'd307;
      heading_deadband = 15'd3277;
      live_words       = 0;
      errors           = 0;
      shown            = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_ARRIVAL_RADIUS:   arrival_radius   = val[14:0];
        REG_FENCE_X_MIN:      fence_x_min      = val;
        REG_FENCE_X_MAX:      fence_x_max      = val;
        REG_FENCE_Y_MIN:      fence_y_min      = val;
        REG_FENCE_Y_MAX:      fence_y_max      = val;
        REG_TURN_RATE_MAX:    turn_rate_max    = val[14:0];
        REG_SPEED_MAX:        speed_max        = val[14:0];
        REG_HEADING_DEADBAND: heading_deadband = val[14:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit has_target();
      return active && (wp_index < wp_count);
    endfunction

    function bit waypoints_left();
      return (wp_count < WP_DEPTH) || (wp_index < wp_count);
    endfunction

    function void step_on();
      wp_index++;
      if (wp_index >= wp_count) active = 1'b0;
    endfunction

    // vectoring CORDIC on (dx, dy) << 8, floor shifts, 32-bit angle
    function void range_bearing(input int dx, input int dy,
                                output int len, output logic signed [15:0] bear);
      longint            x, y, xs, ys;
      longint unsigned   prod;
      logic [31:0]       z, zr;
      int                i;
      len  = 0;
      bear = '0;
      if (dx == 0 && dy == 0) return;
      x = longint'(dx) * 256;
      y = longint'(dy) * 256;
      z = '0;
      if (dx < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_LUT[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_LUT[i];
        end
      end
      if (x < 0) x = 0;
      prod = (longint'(x) * GAIN_INV + 64'd8388608) >> 24;
      len  = (prod > DIST_MAX) ? DIST_MAX : int'(prod);
      zr   = z + 32'h0000_8000;
      bear = zr[31:16];
    endfunction

    function void note_word(logic op_i, logic signed [15:0] x,
                            logic signed [15:0] y, logic signed [15:0] h);
      steer_result_t      r;
      int                 dx, dy, len, mag;
      logic signed [15:0] bear, err;
      r = '{default: '0};
      if (op_i == OP_ADD) begin
        // full store drops the point but still wakes the block
        if (wp_count < WP_DEPTH) begin
          wp_x[wp_count] = x;
          wp_y[wp_count] = y;
          wp_count++;
        end
        active = 1'b1;
        live_words++;
        return;
      end
      if (!active) return;
      live_words++;
      if (wp_index >= wp_count) begin
        active = 1'b0;                 // nothing left: sleep, no result
        return;
      end
      if (x < fence_x_min || x > fence_x_max || y < fence_y_min || y > fence_y_max) begin
        step_on();
        r.ev   = EV_FENCE;
        r.done = !active;
        expected_q.insert(expected_q.size(), r);
        return;
      end
      dx = int'(wp_x[wp_index]) - int'(x);
      dy = int'(wp_y[wp_index]) - int'(y);
      range_bearing(dx, dy, len, bear);
      r.len  = 17'(len);
      r.bear = bear;
      r.hdg  = h;
      if (len < int'(arrival_radius)) begin
        step_on();
        r.ev   = EV_REACHED;
        r.done = !active;
        expected_q.insert(expected_q.size(), r);
        return;
      end
      err = bear + h;                  // wraps like a binary angle
      mag = (err < 0) ? -int'(err) : int'(err);
      if (mag < int'(heading_deadband)) r.turn = '0;
      else if (err > 0)                 r.turn = {1'b0, turn_rate_max};
      else                              r.turn = -{1'b0, turn_rate_max};
      r.speed = speed_max;
      r.ev    = EV_STEER;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void check_result(steer_result_t got);
      steer_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("unexpected result word: ev=%0d turn=%0d speed=%0d dist=%0d",
                   got.ev, got.turn, got.speed, got.len);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.ev !== want.ev || got.turn !== want.turn || got.speed !== want.speed ||
          got.len !== want.len || got.bear !== want.bear || got.hdg !== want.hdg ||
          got.done !== want.done) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("mismatch exp: ev=%0d turn=%0d speed=%0d dist=%0d bear=%0d hdg=%0d done=%0d",
                   want.ev, want.turn, want.speed, want.len, want.bear, want.hdg, want.done);
          $display("         got: ev=%0d turn=%0d speed=%0d dist=%0d bear=%0d hdg=%0d done=%0d",
                   got.ev, got.turn, got.speed, got.len, got.bear, got.hdg, got.done);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_en;
  logic [2:0]          cfg_index;
  logic [15:0]         cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                op;
  logic signed [15:0]  pos_x;
  logic signed [15:0]  pos_y;
  logic signed [15:0]  heading;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          event_res;
  logic signed [15:0]  turn_cmd;
  logic [14:0]         speed_cmd;
  logic [16:0]         distance;
  logic signed [15:0]  bearing;
  logic signed [15:0]  heading_echo;
  logic                all_done;

  int send_idle_pct;   // per-cycle chance the sender holds off
  int recv_idle_pct;   // per-cycle chance the receiver stalls

  steer_scoreboard sb = new();

  waypoint_bang_bang_steering #(
    .WAYPOINT_DEPTH(WP_DEPTH),
    .CORDIC_STEPS  (ROT_STEPS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_res   (event_res),
    .turn_cmd    (turn_cmd),
    .speed_cmd   (speed_cmd),
    .distance    (distance),
    .bearing     (bearing),
    .heading_echo(heading_echo),
    .all_done    (all_done)
  );

  always #HALF_PERIOD clk = ~clk;

  // Receiver: ready changes on the falling edge only.
  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Both channels sampled at the rising edge, before the block updates.
  always @(posedge clk) begin : monitor
    steer_result_t got;
    if (!rst) begin
      if (in_valid && in_ready) sb.note_word(op, pos_x, pos_y, heading);
      if (out_valid && out_ready) begin
        got = '{event_res, turn_cmd, speed_cmd, distance, bearing, heading_echo, all_done};
        sb.check_result(got);
      end
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #5_000_000;
    $display("waypoint_bang_bang_steering test failed");
    $finish;
  end

  // Present one word at the falling edge, hold it until taken, return at the
  // falling edge after acceptance with valid still up.
  task automatic send_word(input logic o, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic signed [15:0] h);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    op       = o;
    pos_x    = x;
    pos_y    = y;
    heading  = h;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_en    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_en    = 1'b0;
  endtask

  // Config only changes with the block quiet: all results in, then a pause
  // for any pose still in flight that gives no result.
  task automatic apply_config(input logic [15:0] radius, input logic [15:0] xmin,
                              input logic [15:0] xmax, input logic [15:0] ymin,
                              input logic [15:0] ymax, input logic [15:0] turn,
                              input logic [15:0] speed, input logic [15:0] band);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write(REG_ARRIVAL_RADIUS, radius);
    cfg_write(REG_FENCE_X_MIN, xmin);
    cfg_write(REG_FENCE_X_MAX, xmax);
    cfg_write(REG_FENCE_Y_MIN, ymin);
    cfg_write(REG_FENCE_Y_MAX, ymax);
    cfg_write(REG_TURN_RATE_MAX, turn);
    cfg_write(REG_SPEED_MAX, speed);
    cfg_write(REG_HEADING_DEADBAND, band);
  endtask

  // Coordinate in [lo, hi], landing on a bound now and then.
  function automatic logic signed [15:0] pick_between(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 16'(lo);
    if (r < 16) return 16'(hi);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic send_noise(input logic o);
    send_word(o, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_inside(input logic o);
    send_word(o, pick_between(sb.fence_x_min, sb.fence_x_max),
              pick_between(sb.fence_y_min, sb.fence_y_max), 16'($urandom));
  endtask

  // Pose one step past a fence bound; falls back to noise when that bound
  // already sits at the end of the range.
  task automatic send_outside();
    logic signed [15:0] x, y;
    int                 side;
    bit                 ok;
    x    = pick_between(sb.fence_x_min, sb.fence_x_max);
    y    = pick_between(sb.fence_y_min, sb.fence_y_max);
    side = $urandom_range(0, 3);
    ok   = 1'b1;
    case (side)
      0: if (sb.fence_x_min != -16'sd32768) x = sb.fence_x_min - 16'sd1; else ok = 1'b0;
      1: if (sb.fence_x_max != 16'sd32767)  x = sb.fence_x_max + 16'sd1; else ok = 1'b0;
      2: if (sb.fence_y_min != -16'sd32768) y = sb.fence_y_min - 16'sd1; else ok = 1'b0;
      default: if (sb.fence_y_max != 16'sd32767) y = sb.fence_y_max + 16'sd1; else ok = 1'b0;
    endcase
    if (ok) send_word(OP_POSE, x, y, 16'($urandom));
    else    send_noise(OP_POSE);
  endtask

  // Pose close to the current waypoint, mostly inside the arrival radius.
  task automatic send_near();
    int rad, tx, ty;
    rad = int'(sb.arrival_radius) / 3;
    tx  = int'(sb.wp_x[sb.wp_index]) + int'($urandom_range(0, 2 * rad)) - rad;
    ty  = int'(sb.wp_y[sb.wp_index]) + int'($urandom_range(0, 2 * rad)) - rad;
    tx  = (tx > 32767) ? 32767 : (tx < -32768) ? -32768 : tx;
    ty  = (ty > 32767) ? 32767 : (ty < -32768) ? -32768 : ty;
    send_word(OP_POSE, 16'(tx), 16'(ty), 16'($urandom));
  endtask

  // Mostly steering poses against a live waypoint; a few adds, fence hits,
  // arrivals and noise. Fence hits and arrivals use up the small store, so
  // they are kept rare.
  task automatic send_random_word();
    int r;
    r = $urandom_range(0, 99);
    if (!sb.has_target() && sb.wp_count < WP_DEPTH && r < 80) send_inside(OP_ADD);
    else if (r < 2)  send_noise(OP_ADD);
    else if (r < 5)  send_inside(OP_ADD);
    else if (r < 7)  send_noise(OP_POSE);
    else if (r < 9)  send_outside();
    else if (r < 12 && sb.has_target()) send_near();
    else             send_inside(OP_POSE);
    // now and then hold off until the block has emptied out
    if ($urandom_range(0, 99) < 2) drain_results();
  endtask

  task automatic set_phase_config(input int p);
    case (p)
      0: apply_config(16'd307, -16'sd1393, 16'sd2048, -16'sd1843, 16'sd2048,
                      16'd614, 16'd307, 16'd3277);
      1: apply_config(16'd1024, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                      16'd0, 16'd0, 16'h7FFF);
      default: apply_config(16'($urandom_range(0, 2000)),
                            16'(int'($urandom_range(0, 30000)) - 32768),
                            16'(int'($urandom_range(0, 30000)) + 2767),
                            16'(int'($urandom_range(0, 30000)) - 32768),
                            16'(int'($urandom_range(0, 30000)) + 2767),
                            16'($urandom), 16'($urandom),
                            16'($urandom_range(0, 8000)));
    endcase
  endtask

  initial begin : stimulus
    int p;
    int goal;
    rst           = 1'b1;
    cfg_en        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    op            = OP_ADD;
    pos_x         = '0;
    pos_y         = '0;
    heading       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 47;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed, reset config ----
    send_word(OP_POSE, 16'sd0, 16'sd0, 16'sd0);             // asleep: ignored
    send_word(OP_ADD, 16'sd0, 16'sd0, 16'sd0);
    send_word(OP_POSE, 16'sd0, 16'sd0, 16'sd0);             // zero vector, reached, last
    send_word(OP_POSE, 16'sd100, 16'sd100, 16'sd100);       // asleep again
    send_word(OP_ADD, 16'sd2048, -16'sd1843, 16'sd0);
    send_word(OP_ADD, -16'sd1393, 16'sd2048, 16'sd0);
    send_word(OP_ADD, -16'sd32768, 16'sd32767, 16'sd0);
    send_word(OP_ADD, 16'sd32767, -16'sd32768, 16'sd0);
    send_word(OP_POSE, -16'sd1393, -16'sd1843, -16'sd32768); // on the corner, error of -pi
    send_word(OP_POSE, 16'sd2048, 16'sd2048, 16'sd32767);    // other corner, left turn
    send_word(OP_POSE, -16'sd1000, -16'sd1843, 16'sd0);      // dead ahead: no turn
    send_word(OP_POSE, -16'sd1394, 16'sd0, 16'sd5);          // just below x bound
    send_word(OP_POSE, 16'sd0, 16'sd2049, -16'sd5);          // just above y bound
    send_word(OP_POSE, -16'sd1393, 16'sd2048, 16'sd16384);   // target behind: dx < 0
    send_word(OP_POSE, 16'sd2049, 16'sd0, 16'sd0);           // just above x bound
    send_word(OP_POSE, -16'sd1393, -16'sd1843, -16'sd16384); // dx beyond 16 bits
    send_word(OP_POSE, 16'sd0, -16'sd1844, 16'sd0);          // fence on the last one

    // crossed fence: every pose is out; 15-bit registers get bit 15 set
    apply_config(16'hFFFF, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                 16'd0, 16'd0, 16'hFFFF);
    send_word(OP_ADD, 16'sd100, 16'sd100, 16'sd0);
    send_word(OP_POSE, 16'sd0, 16'sd0, 16'sd0);

    // open fence, zero radius and zero deadband, full turn and speed
    apply_config(16'd0, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                 16'hFFFF, 16'hFFFF, 16'd0);
    send_word(OP_ADD, 16'sd5, 16'sd5, 16'sd0);
    send_word(OP_POSE, 16'sd5, 16'sd5, 16'sd0);              // on target, never reached
    send_word(OP_POSE, -16'sd32768, -16'sd32768, 16'sd32767);
    send_word(OP_POSE, 16'sd32767, 16'sd32767, -16'sd1);

    // widest radius and deadband
    apply_config(16'h7FFF, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                 16'd1, 16'd1, 16'h7FFF);
    send_word(OP_POSE, 16'sd32767, 16'sd32767, -16'sd32768);
    send_word(OP_POSE, -16'sd32768, 16'sd5, 16'sd0);
    send_word(OP_POSE, 16'sd5, 16'sd5, 16'sd0);              // reached, last

    // ---- random phases: sender-light, receiver-light, then no idling ----
    goal = sb.live_words;
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      set_phase_config(p);
      goal = goal + PHASE_WORDS;
      while (sb.live_words < goal && sb.waypoints_left()) send_random_word();
    end

    // ---- closing: fill the store, overflow it, pass everything ----
    set_phase_config(0);
    while (sb.wp_count < WP_DEPTH) send_inside(OP_ADD);
    repeat (2) send_noise(OP_ADD);                           // dropped
    while (sb.has_target()) begin
      send_word(OP_POSE, sb.fence_x_max + 16'sd1, 16'sd0, 16'($urandom));
    end
    send_noise(OP_ADD);                                      // dropped, still wakes
    send_noise(OP_POSE);                                     // nothing left: sleeps
    send_noise(OP_POSE);                                     // asleep: ignored

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("waypoint_bang_bang_steering test passed");
    end else begin
      $display("waypoint_bang_bang_steering test failed");
    end
    $finish;
  end

endmodule
